[rtl/core/lzbd_pkg.sv]
package lzbd_pkg;

	localparam int unsigned ByteW           = 8;
	localparam int unsigned HdrW            = 3;
	localparam int unsigned OutCntW         = 17;
	localparam int unsigned RingAw          = 12;
	localparam int unsigned RingDepth       = 1 << RingAw;
	localparam int unsigned LenW            = 4;
	localparam int unsigned CtrlW           = 16;
	localparam int unsigned CtrlCntW        = 5;
	localparam int unsigned CfgIdxW         = 1;
	localparam int unsigned CfgDataW        = 8;
	localparam int unsigned MaxBlockDefault = 65536;

	localparam logic [CfgIdxW-1:0] CFG_COPY_FLAG    = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_HEADER_BYTES = 1'b1;

	localparam logic [ByteW-1:0] CopyFlagReset    = 8'd1;
	localparam logic [HdrW-1:0]  HeaderBytesReset = 3'd4;

	typedef struct packed {
		logic clr_wr;
		logic emit_in;
		logic hold;
		logic copy_start;
		logic copy_rd;
		logic copy_wr;
		logic run_last;
		logic block_end;
		logic blk_clr;
	} lzbd_cmd_t;

	typedef struct packed {
		logic out_free;
		logic wp_last;
		logic cnt_zero;
	} lzbd_stat_t;

endpackage

[rtl/core/lzbd_in_if.sv]
interface lzbd_in_if;
	logic                        valid;
	logic                        ready;
	logic [lzbd_pkg::ByteW-1:0]  in_byte;
	logic                        block_last;

	modport source (output valid, output in_byte, output block_last, input ready);
	modport sink (input valid, input in_byte, input block_last, output ready);
endinterface

[rtl/core/lzbd_out_if.sv]
interface lzbd_out_if;
	logic                          valid;
	logic                          ready;
	logic [lzbd_pkg::ByteW-1:0]    out_byte;
	logic                          run_last;
	logic                          block_end;
	logic [lzbd_pkg::OutCntW-1:0]  out_count;

	modport source (
		output valid, output out_byte, output run_last, output block_end, output out_count,
		input ready
	);
	modport sink (
		input valid, input out_byte, input run_last, input block_end, input out_count,
		output ready
	);
endinterface

[rtl/core/lz_block_decompressor_unit.sv]
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    in_byte[7:0], block_last
// out_ch    out  valid/ready    out_byte[7:0], run_last, block_end, out_count[16:0]
// cfg       in   cfg_we         cfg_index[0], cfg_wdata[7:0]
//
// After reset a clearing pass zeroes the 4096-byte history ring, one entry per cycle:
// in_ch.ready stays low during the pass. Header, control and literal bytes are taken while
// the sequencer runs and the output register is free. The second byte of a copy item
// starts a loop that, per emitted byte, does a registered ring read, then write-back and
// output load; in_ch.ready stays low until the copy is done.
// A stalled out_ch holds the sequencer; one result waits in the output register.
module lz_block_decompressor_unit #(
	parameter int unsigned MAX_BLOCK = lzbd_pkg::MaxBlockDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lzbd_in_if.sink                       in_ch,
	lzbd_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [lzbd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lzbd_pkg::CfgDataW-1:0] cfg_wdata
);

	lzbd_pkg::lzbd_cmd_t  cmd;
	lzbd_pkg::lzbd_stat_t stat;

	lzbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.cmd       (cmd)
	);

	lzbd_datapath #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_byte (in_ch.in_byte),
		.stat    (stat),
		.out_ch  (out_ch)
	);

	a_wr_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_wr |-> stat.out_free)
		else $error("copy byte loaded over a pending result");

	a_wr_port: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.emit_in, cmd.copy_wr}))
		else $error("ring write port driven by two sources");

	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_rd |=> (cmd.copy_wr || !stat.out_free))
		else $error("ring read not followed by write-back");

	a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> !(cmd.copy_wr || cmd.copy_rd || cmd.clr_wr))
		else $error("transfer accepted while copy or clear in progress");

endmodule

[rtl/core/lzbd_ctrl.sv]
module lzbd_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	lzbd_in_if.sink                           in_ch,
	input  logic                              cfg_we,
	input  logic [lzbd_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [lzbd_pkg::CfgDataW-1:0]     cfg_wdata,
	input  lzbd_pkg::lzbd_stat_t              stat,
	output lzbd_pkg::lzbd_cmd_t               cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_RUN,
		S_RD,
		S_WR
	} seq_t;

	typedef enum logic [2:0] {
		PH_FLAG,
		PH_HDR_C,
		PH_HDR_S,
		PH_STORED,
		PH_CTRL_LO,
		PH_CTRL_HI,
		PH_ITEM,
		PH_COPY2
	} phase_t;

	seq_t                                 seq_q;
	phase_t                               phase_q;
	logic [lzbd_pkg::HdrW-1:0]            hdr_left_q;
	logic [lzbd_pkg::CtrlW-1:0]           ctrl_word_q;
	logic [lzbd_pkg::CtrlCntW-1:0]        ctrl_left_q;
	logic                                 copy_last_q;
	logic [lzbd_pkg::ByteW-1:0]           copy_flag_q;
	logic [lzbd_pkg::HdrW-1:0]            hdr_bytes_q;

	logic                                 accept;
	logic [lzbd_pkg::HdrW-1:0]            hdr_dec;
	logic [lzbd_pkg::HdrW-1:0]            hdr_eff;
	logic [lzbd_pkg::CtrlCntW-1:0]        ctrl_dec;
	phase_t                               phase_done;

	assign in_ch.ready = (seq_q == S_RUN) && stat.out_free;
	assign accept      = in_ch.valid && in_ch.ready;
	assign hdr_dec     = (hdr_left_q == '0) ? '0 : hdr_left_q - 1'b1;
	assign hdr_eff     = (hdr_bytes_q == '0) ? lzbd_pkg::HdrW'(1) : hdr_bytes_q;
	assign ctrl_dec    = (ctrl_left_q == '0) ? '0 : ctrl_left_q - 1'b1;
	assign phase_done  = (ctrl_dec == '0) ? PH_CTRL_LO : PH_ITEM;

	always_comb begin
		cmd = '0;
		unique case (seq_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			S_RUN: begin
				if (accept) begin
					cmd.blk_clr = in_ch.block_last && (phase_q != PH_COPY2);
					unique case (phase_q)
						PH_STORED: begin
							cmd.emit_in   = 1'b1;
							cmd.run_last  = 1'b1;
							cmd.block_end = in_ch.block_last;
						end
						PH_ITEM: begin
							if (ctrl_word_q[0]) begin
								cmd.hold = 1'b1;
							end else begin
								cmd.emit_in   = 1'b1;
								cmd.run_last  = 1'b1;
								cmd.block_end = in_ch.block_last;
							end
						end
						PH_COPY2: begin
							cmd.copy_start = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_RD: begin
				cmd.copy_rd = 1'b1;
			end
			S_WR: begin
				if (stat.out_free) begin
					cmd.copy_wr   = 1'b1;
					cmd.run_last  = stat.cnt_zero;
					cmd.block_end = stat.cnt_zero && copy_last_q;
					cmd.blk_clr   = stat.cnt_zero && copy_last_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= S_CLEAR;
			phase_q     <= PH_FLAG;
			hdr_left_q  <= lzbd_pkg::HeaderBytesReset;
			ctrl_word_q <= '0;
			ctrl_left_q <= '0;
			copy_last_q <= 1'b0;
			copy_flag_q <= lzbd_pkg::CopyFlagReset;
			hdr_bytes_q <= lzbd_pkg::HeaderBytesReset;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lzbd_pkg::CFG_COPY_FLAG:    copy_flag_q <= cfg_wdata;
					lzbd_pkg::CFG_HEADER_BYTES: hdr_bytes_q <= cfg_wdata[lzbd_pkg::HdrW-1:0];
				endcase
			end

			unique case (seq_q)
				S_CLEAR: begin
					if (stat.wp_last) begin
						seq_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (accept) begin
						unique case (phase_q)
							PH_FLAG: begin
								hdr_left_q <= hdr_dec;
								if (in_ch.in_byte == copy_flag_q) begin
									phase_q <= (hdr_dec == '0) ? PH_STORED : PH_HDR_S;
								end else begin
									phase_q <= (hdr_dec == '0) ? PH_CTRL_LO : PH_HDR_C;
								end
							end
							PH_HDR_C: begin
								hdr_left_q <= hdr_dec;
								if (hdr_dec == '0) begin
									phase_q <= PH_CTRL_LO;
								end
							end
							PH_HDR_S: begin
								hdr_left_q <= hdr_dec;
								if (hdr_dec == '0) begin
									phase_q <= PH_STORED;
								end
							end
							PH_STORED: begin
							end
							PH_CTRL_LO: begin
								ctrl_word_q <= {{(lzbd_pkg::CtrlW-lzbd_pkg::ByteW){1'b0}}, in_ch.in_byte};
								phase_q     <= PH_CTRL_HI;
							end
							PH_CTRL_HI: begin
								ctrl_word_q <= {in_ch.in_byte, ctrl_word_q[lzbd_pkg::ByteW-1:0]};
								ctrl_left_q <= lzbd_pkg::CtrlCntW'(lzbd_pkg::CtrlW);
								phase_q     <= PH_ITEM;
							end
							PH_ITEM: begin
								if (ctrl_word_q[0]) begin
									phase_q <= PH_COPY2;
								end else begin
									ctrl_word_q <= ctrl_word_q >> 1;
									ctrl_left_q <= ctrl_dec;
									phase_q     <= phase_done;
								end
							end
							PH_COPY2: begin
								ctrl_word_q <= ctrl_word_q >> 1;
								ctrl_left_q <= ctrl_dec;
								phase_q     <= phase_done;
								copy_last_q <= in_ch.block_last;
								seq_q       <= S_RD;
							end
						endcase
						if (in_ch.block_last) begin
							phase_q     <= PH_FLAG;
							hdr_left_q  <= hdr_eff;
							ctrl_word_q <= '0;
							ctrl_left_q <= '0;
						end
					end
				end
				S_RD: begin
					seq_q <= S_WR;
				end
				S_WR: begin
					if (stat.out_free) begin
						seq_q <= stat.cnt_zero ? S_RUN : S_RD;
					end
				end
			endcase
		end
	end

endmodule

[rtl/core/lzbd_datapath.sv]
module lzbd_datapath #(
	parameter int unsigned MAX_BLOCK = lzbd_pkg::MaxBlockDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lzbd_pkg::lzbd_cmd_t           cmd,
	input  logic [lzbd_pkg::ByteW-1:0]    in_byte,
	output lzbd_pkg::lzbd_stat_t          stat,
	lzbd_out_if.source                    out_ch
);

	localparam int unsigned CntW = $clog2(MAX_BLOCK + 1);

	logic [lzbd_pkg::ByteW-1:0]   ring_mem [lzbd_pkg::RingDepth];

	logic [lzbd_pkg::RingAw-1:0]  wp_q;
	logic [lzbd_pkg::RingAw-1:0]  src_q;
	logic [lzbd_pkg::LenW-1:0]    len_q;
	logic [lzbd_pkg::ByteW-1:0]   held_q;
	logic [lzbd_pkg::ByteW-1:0]   rdata_q;
	logic [CntW-1:0]              count_q;
	logic                         out_valid_q;
	logic [lzbd_pkg::ByteW-1:0]   out_byte_q;
	logic                         run_last_q;
	logic                         block_end_q;
	logic [lzbd_pkg::OutCntW-1:0] out_count_q;

	logic                         wr_en;
	logic                         emit;
	logic [lzbd_pkg::ByteW-1:0]   wr_data;
	logic [CntW-1:0]              count_inc;
	logic [lzbd_pkg::RingAw-1:0]  offset;

	assign emit      = cmd.emit_in || cmd.copy_wr;
	assign wr_en     = cmd.clr_wr || emit;
	assign wr_data   = cmd.copy_wr ? rdata_q : (cmd.emit_in ? in_byte : '0);
	assign count_inc = (count_q < CntW'(MAX_BLOCK)) ? count_q + CntW'(1) : count_q;
	assign offset    = {held_q[lzbd_pkg::ByteW-1:lzbd_pkg::LenW], in_byte};

	assign stat.out_free = !out_valid_q || out_ch.ready;
	assign stat.wp_last  = &wp_q;
	assign stat.cnt_zero = (len_q == '0);

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_byte  = out_byte_q;
	assign out_ch.run_last  = run_last_q;
	assign out_ch.block_end = block_end_q;
	assign out_ch.out_count = out_count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wp_q] <= wr_data;
		end
		if (cmd.copy_rd) begin
			rdata_q <= ring_mem[src_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			held_q <= in_byte;
		end
		if (cmd.copy_start) begin
			src_q <= wp_q - offset;
			len_q <= held_q[lzbd_pkg::LenW-1:0];
		end else begin
			if (cmd.copy_rd) begin
				src_q <= src_q + 1'b1;
			end
			if (cmd.copy_wr) begin
				len_q <= len_q - 1'b1;
			end
		end
		if (emit) begin
			out_byte_q  <= wr_data;
			run_last_q  <= cmd.run_last;
			block_end_q <= cmd.block_end;
			out_count_q <= lzbd_pkg::OutCntW'(count_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (cmd.blk_clr) begin
				count_q <= '0;
			end else if (emit) begin
				count_q <= count_inc;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[test/lz_block_decompressor_unit_test.sv]
module lz_block_decompressor_unit_test;

	localparam int unsigned BlockCap = 4096;

	typedef enum logic [2:0] {
		S_FLAG, S_HDR_C, S_HDR_S, S_STORED, S_CTRL_LO, S_CTRL_HI, S_ITEM, S_COPY2
	} parse_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        run_last;
		logic        block_end;
		logic [16:0] count;
	} decoded_t;

	typedef struct packed {
		logic [7:0] b;
		logic       lst;
	} coded_t;

	typedef struct packed {
		logic [7:0] b;
		logic       lst;
		logic       typed;
		decoded_t   want;
	} script_row_t;

	localparam decoded_t NONE = '0;

	script_row_t script [23] = '{
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'hAA, 1'b0, 1'b0, NONE},
		'{8'hBB, 1'b0, 1'b0, NONE},
		'{8'hCC, 1'b0, 1'b0, NONE},
		'{8'h79, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'h05, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 17'd1}},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 17'd2}},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 17'd3}},
		'{8'h0F, 1'b0, 1'b0, NONE},
		'{8'h02, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'hF3, 1'b0, 1'b0, NONE},
		'{8'hFF, 1'b0, 1'b0, NONE},
		'{8'h12, 1'b1, 1'b0, NONE},
		'{8'h01, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'hFF, 1'b0, 1'b0, NONE},
		'{8'h55, 1'b0, 1'b0, NONE},
		'{8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, 17'd1}},
		'{8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b1, 17'd2}}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lzbd_pkg::CfgIdxW-1:0] cfg_index;
	logic [lzbd_pkg::CfgDataW-1:0] cfg_wdata;

	lzbd_in_if in_ch ();
	lzbd_out_if out_ch ();

	lz_block_decompressor_unit #(
		.MAX_BLOCK(BlockCap)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	logic [7:0] flag_reg;
	logic [2:0] hdr_reg;
	parse_t pstate;
	logic [2:0] hdr_left;
	logic [15:0] ctrl_bits;
	logic [4:0] ctrl_left;
	logic [7:0] held;
	logic [7:0] history [lzbd_pkg::RingDepth];
	logic [11:0] wr_pos;
	logic [16:0] out_total;

	decoded_t step_res[$];
	decoded_t awaited_q[$];
	int unsigned mismatch_cnt = 0;
	int unsigned fed = 0;
	int unsigned stall = 0;
	bit calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [11:0] pick_offset();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6) return 12'($urandom_range(1, 40));
		if (r < 9) return 12'($urandom);
		return 12'd0;
	endfunction

	function automatic void restart_block();
		pstate = S_FLAG;
		hdr_left = (hdr_reg == 3'd0) ? 3'd1 : hdr_reg;
		ctrl_bits = '0;
		ctrl_left = '0;
		held = '0;
		out_total = '0;
	endfunction

	function automatic void emit_byte(input logic [7:0] v);
		decoded_t r;
		history[wr_pos] = v;
		wr_pos = wr_pos + 12'd1;
		if (out_total < BlockCap) out_total = out_total + 17'd1;
		r.data = v;
		r.run_last = 1'b0;
		r.block_end = 1'b0;
		r.count = out_total;
		step_res.push_back(r);
	endfunction

	function automatic void next_item();
		ctrl_bits = ctrl_bits >> 1;
		if (ctrl_left > 0) ctrl_left = ctrl_left - 5'd1;
		pstate = (ctrl_left == 0) ? S_CTRL_LO : S_ITEM;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic lst);
		logic [11:0] src;
		int n;
		decoded_t tail;
		step_res.delete();
		case (pstate)
			S_FLAG: begin
				if (hdr_left > 0) hdr_left = hdr_left - 3'd1;
				if (b == flag_reg) pstate = (hdr_left == 0) ? S_STORED : S_HDR_S;
				else pstate = (hdr_left == 0) ? S_CTRL_LO : S_HDR_C;
			end
			S_HDR_C, S_HDR_S: begin
				if (hdr_left > 0) hdr_left = hdr_left - 3'd1;
				if (hdr_left == 0) pstate = (pstate == S_HDR_S) ? S_STORED : S_CTRL_LO;
			end
			S_STORED: emit_byte(b);
			S_CTRL_LO: begin
				ctrl_bits = {8'h00, b};
				pstate = S_CTRL_HI;
			end
			S_CTRL_HI: begin
				ctrl_bits[15:8] = b;
				ctrl_left = 5'd16;
				pstate = S_ITEM;
			end
			S_ITEM: begin
				if (ctrl_bits[0]) begin
					held = b;
					pstate = S_COPY2;
				end else begin
					emit_byte(b);
					next_item();
				end
			end
			default: begin
				src = wr_pos - {held[7:4], b};
				n = held[3:0] + 1;
				repeat (n) begin
					emit_byte(history[src]);
					src = src + 12'd1;
				end
				next_item();
			end
		endcase
		if (step_res.size() > 0) begin
			tail = step_res.pop_back();
			tail.run_last = 1'b1;
			tail.block_end = lst;
			step_res.push_back(tail);
		end
		if (lst) restart_block();
	endfunction

	task automatic report(input string what, input decoded_t want, input decoded_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t %s: expected %02h/%0b/%0b/%0d got %02h/%0b/%0b/%0d", $time, what,
				want.data, want.run_last, want.block_end, want.count,
				got.data, got.run_last, got.block_end, got.count);
	endtask

	always @(posedge clk) begin
		decoded_t got;
		decoded_t want;
		if (arst_n) begin
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got = '{out_ch.out_byte, out_ch.run_last, out_ch.block_end, out_ch.out_count};
				if (awaited_q.size() == 0) begin
					report("unexpected transfer", NONE, got);
				end else begin
					want = awaited_q.pop_front();
					if (got.data !== want.data || got.run_last !== want.run_last ||
						got.block_end !== want.block_end || got.count !== want.count)
						report("mismatch", want, got);
				end
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else begin
				out_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end else begin
			out_ch.ready <= 1'b0;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic lst, input logic typed,
		input decoded_t want);
		int unsigned g;
		g = pick_gap();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.block_last <= lst;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		decode_byte(b, lst);
		if (typed) awaited_q.push_back(want);
		else foreach (step_res[i]) awaited_q.push_back(step_res[i]);
		fed++;
	endtask

	task automatic drain(input int unsigned tail_cycles);
		in_ch.valid <= 1'b0;
		while (awaited_q.size() != 0) @(posedge clk);
		repeat (tail_cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lzbd_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == lzbd_pkg::CFG_COPY_FLAG) flag_reg = val;
		else hdr_reg = val[2:0];
	endtask

	task automatic send_block(input bit stored_req, input int unsigned n_items,
		input bit clip, input bit dense);
		coded_t q[$];
		coded_t tail;
		int unsigned nh;
		bit stored;
		logic [15:0] ctrl;
		logic [7:0] f;
		logic [11:0] ofs;
		logic [3:0] len;
		stored = stored_req;
		nh = 0;
		ctrl = '0;
		case (pstate)
			S_FLAG: begin
				f = 8'($urandom);
				if (stored) f = flag_reg;
				else if (f == flag_reg) f = f + 8'd1;
				q.push_back('{f, 1'b0});
				nh = hdr_left - 1;
			end
			S_HDR_C, S_HDR_S: begin
				stored = (pstate == S_HDR_S);
				nh = hdr_left;
			end
			S_STORED: stored = 1'b1;
			default: stored = 1'b0;
		endcase
		repeat (nh) q.push_back('{8'($urandom), 1'b0});
		for (int k = 0; k < n_items; k++) begin
			if (stored) begin
				q.push_back('{8'($urandom), 1'b0});
			end else begin
				if (k % 16 == 0) begin
					ctrl = dense ? 16'hFFFF : 16'($urandom);
					q.push_back('{ctrl[7:0], 1'b0});
					q.push_back('{ctrl[15:8], 1'b0});
				end
				if (ctrl[k % 16]) begin
					len = dense ? 4'hF : 4'($urandom);
					ofs = pick_offset();
					q.push_back('{{ofs[11:8], len}, 1'b0});
					q.push_back('{ofs[7:0], 1'b0});
				end else begin
					q.push_back('{8'($urandom), 1'b0});
				end
			end
		end
		if (clip) q = q[0:$urandom_range(0, q.size() - 1)];
		tail = q.pop_back();
		tail.lst = 1'b1;
		q.push_back(tail);
		foreach (q[i]) send_item(q[i].b, q[i].lst, 1'b0, NONE);
	endtask

	task automatic send_noise();
		int unsigned n;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++)
			send_item(8'($urandom), (i == n - 1) || ($urandom_range(0, 5) == 0), 1'b0, NONE);
	endtask

	logic [7:0] phase_flag [8] = '{8'h00, 8'hFF, 8'h5A, 8'h80, 8'hFF, 8'h00, 8'h01, 8'hC3};
	logic [2:0] phase_hdr [8] = '{3'd1, 3'd7, 3'd0, 3'd2, 3'd5, 3'd3, 3'd4, 3'd6};

	initial begin
		int unsigned start;
		int unsigned r;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.in_byte <= '0;
		in_ch.block_last <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= lzbd_pkg::CFG_COPY_FLAG;
		cfg_wdata <= '0;
		flag_reg = lzbd_pkg::CopyFlagReset;
		hdr_reg = lzbd_pkg::HeaderBytesReset;
		foreach (history[i]) history[i] = 8'h00;
		wr_pos = '0;
		restart_block();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) send_item(script[i].b, script[i].lst, script[i].typed, script[i].want);

		// one compressed block of maximum-length copies
		send_block(1'b0, 4, 1'b0, 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			drain(40);
			write_reg(lzbd_pkg::CFG_COPY_FLAG, phase_flag[ph]);
			write_reg(lzbd_pkg::CFG_HEADER_BYTES, {5'd0, phase_hdr[ph]});
			cfg_we <= 1'b0;
			calm = (ph == 2) || (ph == 5);
			start = fed;
			while (fed - start < 6) begin
				r = $urandom_range(0, 9);
				if (r < 4) send_block(1'b0, $urandom_range(1, 8), 1'b0, 1'b0);
				else if (r < 7) send_block(1'b1, $urandom_range(1, 6), 1'b0, 1'b0);
				else if (r < 9)
					send_block(1'($urandom_range(0, 1)), $urandom_range(1, 8), 1'b1, 1'b0);
				else send_noise();
			end
			// leave a header open across the next register change
			if (ph % 2 == 1) send_item(8'($urandom), 1'b0, 1'b0, NONE);
		end

		drain(100);
		if (mismatch_cnt == 0 && awaited_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
